### hw/rtl/bplm_pkg.sv
package bplm_pkg;

   localparam int REQ_W = 3;
   localparam int BIDX_W = 4;
   localparam int OUT_W = 2;
   localparam int ST_W = 3;

   // request codes
   localparam logic [REQ_W-1:0] REQ_CLAIM_FILL = 3'd0;
   localparam logic [REQ_W-1:0] REQ_CLAIM_PROC = 3'd1;
   localparam logic [REQ_W-1:0] REQ_FILLED = 3'd2;
   localparam logic [REQ_W-1:0] REQ_UNFILLED = 3'd3;
   localparam logic [REQ_W-1:0] REQ_PROCESSED = 3'd4;
   localparam logic [REQ_W-1:0] REQ_WRITTEN = 3'd5;

   // buffer status codes
   localparam logic [ST_W-1:0] ST_EMPTY = 3'd0;
   localparam logic [ST_W-1:0] ST_FILLING = 3'd1;
   localparam logic [ST_W-1:0] ST_FILLED = 3'd2;
   localparam logic [ST_W-1:0] ST_PROCESSING = 3'd3;
   localparam logic [ST_W-1:0] ST_PROCESSED = 3'd4;
   localparam logic [ST_W-1:0] ST_WRITTEN = 3'd5;

   // outcome codes
   localparam logic [OUT_W-1:0] OUT_DONE = 2'd0;
   localparam logic [OUT_W-1:0] OUT_NONE = 2'd1;
   localparam logic [OUT_W-1:0] OUT_FULL = 2'd2;
   localparam logic [OUT_W-1:0] OUT_UNUSED = 2'd3;

   typedef enum logic [1:0] {
      S_IDLE,
      S_READ,
      S_EXEC,
      S_RESP
   } state_type;

   typedef struct packed {
      logic latch;
      logic exec;
      logic load;
   } cmd_type;

   typedef struct packed {
      logic rsp_busy;
   } stat_type;

endpackage

### hw/rtl/bplm_ram.sv
module bplm_ram #(
   parameter int WIDTH = 4,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

### hw/rtl/bplm_ctrl.sv
module bplm_ctrl import bplm_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   input  stat_type stat,
   output cmd_type  cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) state_in = S_READ;
         end
         S_READ: state_in = S_EXEC;
         S_EXEC: state_in = S_RESP;
         S_RESP: begin
            if (!stat.rsp_busy) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      cmd = '0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            cmd.latch = req_valid;
         end
         S_READ: ;
         S_EXEC: cmd.exec = 1'b1;
         S_RESP: cmd.load = !stat.rsp_busy;
         default: ;
      endcase
   end

endmodule

### hw/rtl/bplm_dp.sv
module bplm_dp import bplm_pkg::*; #(
   parameter int NUM_BUFFERS = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  cmd_type           cmd,
   output stat_type          stat,
   input  logic [REQ_W-1:0]  req_type,
   input  logic [BIDX_W-1:0] req_buffer_index,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [BIDX_W-1:0] rsp_granted_index,
   output logic [OUT_W-1:0]  rsp_outcome
);

   localparam int IDX_W = $clog2(NUM_BUFFERS);
   localparam int CNT_W = $clog2(NUM_BUFFERS + 1);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_BUFFERS - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(NUM_BUFFERS);
   localparam logic [IDX_W:0] WRAP = (IDX_W+1)'(NUM_BUFFERS);

   logic [REQ_W-1:0]  type_ff;
   logic [BIDX_W-1:0] idx_ff;
   logic [IDX_W-1:0]  free_head_ff, free_head_in, ready_head_ff, ready_head_in;
   logic [CNT_W-1:0]  free_count_ff, free_count_in, ready_count_ff, ready_count_in;
   logic [NUM_BUFFERS-1:0] free_vld_ff, free_vld_in, stat_vld_ff, stat_vld_in;
   logic [IDX_W-1:0]  granted_ff, granted_in;
   logic [OUT_W-1:0]  outcome_ff, outcome_in;
   logic              rsp_valid_ff;
   logic [BIDX_W-1:0] rsp_granted_ff;
   logic [OUT_W-1:0]  rsp_outcome_ff;

   logic              st_we, fq_we, rq_we;
   logic [IDX_W-1:0]  st_waddr, fq_waddr, rq_waddr, fq_wdata, rq_wdata;
   logic [ST_W-1:0]   st_wdata, st_rdata, cur_status, partner;
   logic [IDX_W-1:0]  fq_rdata, rq_rdata, b_idx, free_pop, free_tail, ready_tail;
   logic [IDX_W:0]    free_sum, ready_sum;
   logic              in_range;

   bplm_ram #(.WIDTH(ST_W), .DEPTH(NUM_BUFFERS)) u_status (
      .clock(clock), .we(st_we), .waddr(st_waddr), .wdata(st_wdata),
      .raddr(b_idx), .rdata(st_rdata)
   );

   bplm_ram #(.WIDTH(IDX_W), .DEPTH(NUM_BUFFERS)) u_free_q (
      .clock(clock), .we(fq_we), .waddr(fq_waddr), .wdata(fq_wdata),
      .raddr(free_head_ff), .rdata(fq_rdata)
   );

   bplm_ram #(.WIDTH(IDX_W), .DEPTH(NUM_BUFFERS)) u_ready_q (
      .clock(clock), .we(rq_we), .waddr(rq_waddr), .wdata(rq_wdata),
      .raddr(ready_head_ff), .rdata(rq_rdata)
   );

   assign b_idx = IDX_W'(idx_ff);
   assign in_range = 32'(idx_ff) < NUM_BUFFERS;

   // untouched status entries read as empty, untouched free entries hold their own index
   assign cur_status = stat_vld_ff[b_idx] ? st_rdata : ST_EMPTY;
   assign free_pop = free_vld_ff[free_head_ff] ? fq_rdata : free_head_ff;
   assign partner = (type_ff == REQ_PROCESSED) ? ST_WRITTEN : ST_PROCESSED;

   // tail = (head + count) mod N; sum stays below 2N on a push
   assign free_sum = (IDX_W+1)'(free_head_ff) + (IDX_W+1)'(free_count_ff);
   assign ready_sum = (IDX_W+1)'(ready_head_ff) + (IDX_W+1)'(ready_count_ff);
   assign free_tail = IDX_W'((free_sum >= WRAP) ? free_sum - WRAP : free_sum);
   assign ready_tail = IDX_W'((ready_sum >= WRAP) ? ready_sum - WRAP : ready_sum);

   always_comb begin
      st_we = 1'b0;
      st_waddr = b_idx;
      st_wdata = ST_EMPTY;
      fq_we = 1'b0;
      fq_waddr = free_tail;
      fq_wdata = b_idx;
      rq_we = 1'b0;
      rq_waddr = ready_tail;
      rq_wdata = b_idx;
      free_head_in = free_head_ff;
      free_count_in = free_count_ff;
      ready_head_in = ready_head_ff;
      ready_count_in = ready_count_ff;
      free_vld_in = free_vld_ff;
      stat_vld_in = stat_vld_ff;
      granted_in = granted_ff;
      outcome_in = outcome_ff;
      if (cmd.exec) begin
         granted_in = '0;
         outcome_in = OUT_DONE;
         case (type_ff) inside
            REQ_CLAIM_FILL: begin
               if (free_count_ff == '0) begin
                  outcome_in = OUT_NONE;
               end else begin
                  granted_in = free_pop;
                  free_head_in = (free_head_ff == LAST_IDX) ? '0 : free_head_ff + 1'b1;
                  free_count_in = free_count_ff - 1'b1;
                  st_we = 1'b1;
                  st_waddr = free_pop;
                  st_wdata = ST_FILLING;
               end
            end
            REQ_CLAIM_PROC: begin
               if (ready_count_ff == '0) begin
                  outcome_in = OUT_NONE;
               end else begin
                  granted_in = rq_rdata;
                  ready_head_in = (ready_head_ff == LAST_IDX) ? '0 : ready_head_ff + 1'b1;
                  ready_count_in = ready_count_ff - 1'b1;
                  st_we = 1'b1;
                  st_waddr = rq_rdata;
                  st_wdata = ST_PROCESSING;
               end
            end
            REQ_FILLED: begin
               if (in_range) begin
                  st_we = 1'b1;
                  st_wdata = ST_FILLED;
                  if (ready_count_ff == FULL_CNT) begin
                     outcome_in = OUT_FULL;
                  end else begin
                     rq_we = 1'b1;
                     ready_count_in = ready_count_ff + 1'b1;
                  end
               end
            end
            REQ_UNFILLED, REQ_PROCESSED, REQ_WRITTEN: begin
               if (in_range) begin
                  st_we = 1'b1;
                  if (type_ff != REQ_UNFILLED && cur_status != partner) begin
                     st_wdata = (type_ff == REQ_PROCESSED) ? ST_PROCESSED : ST_WRITTEN;
                  end else begin
                     st_wdata = ST_EMPTY;
                     if (free_count_ff == FULL_CNT) begin
                        outcome_in = OUT_FULL;
                     end else begin
                        fq_we = 1'b1;
                        free_count_in = free_count_ff + 1'b1;
                     end
                  end
               end
            end
            default: ;
         endcase
         if (st_we) stat_vld_in[st_waddr] = 1'b1;
         if (fq_we) free_vld_in[fq_waddr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         free_head_ff <= '0;
         free_count_ff <= FULL_CNT;
         ready_head_ff <= '0;
         ready_count_ff <= '0;
         free_vld_ff <= '0;
         stat_vld_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         free_head_ff <= free_head_in;
         free_count_ff <= free_count_in;
         ready_head_ff <= ready_head_in;
         ready_count_ff <= ready_count_in;
         free_vld_ff <= free_vld_in;
         stat_vld_ff <= stat_vld_in;
         if (cmd.load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         type_ff <= req_type;
         idx_ff <= req_buffer_index;
      end
      granted_ff <= granted_in;
      outcome_ff <= outcome_in;
      if (cmd.load) begin
         rsp_granted_ff <= BIDX_W'(granted_ff);
         rsp_outcome_ff <= outcome_ff;
      end
   end

   assign stat.rsp_busy = rsp_valid_ff && !rsp_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_granted_index = rsp_granted_ff;
   assign rsp_outcome = rsp_outcome_ff;

endmodule

### hw/rtl/buffer_pool_lifecycle_manager_top.sv
// Buffer pool lifecycle manager.
// req_ channel: one beat is a request (req_type, req_buffer_index): claim a
// buffer to fill, claim a filled buffer to process, or return a buffer as
// filled, unfilled, processed or written. rsp_ channel: exactly one beat per
// request with the granted buffer (zero unless a claim succeeds) and an
// outcome: done, no buffer available, or queue full with the push dropped.
// A buffer rejoins the empty queue once both processed and written arrive.
// Timing: a request is taken in idle, the status table and queue heads are
// read in the next cycle (registered RAM reads), updated in the cycle after,
// and the response register loads in S_RESP once it is free. A new request
// is taken only after the previous one has loaded its response. The
// response register lets the next request be accepted while a response
// still waits; if rsp_ready stays low, the following request holds in its
// last step until the register frees.
// Reset (synchronous) marks every buffer empty, fills the empty queue with
// buffers 0 to NUM_BUFFERS-1 in order and empties the filled queue; no
// clearing pass is needed, so requests are taken right after reset.
module buffer_pool_lifecycle_manager_top import bplm_pkg::*; #(
   parameter int NUM_BUFFERS = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [REQ_W-1:0]  req_type,
   input  logic [BIDX_W-1:0] req_buffer_index,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [BIDX_W-1:0] rsp_granted_index,
   output logic [OUT_W-1:0]  rsp_outcome
);

   cmd_type  cmd;
   stat_type stat;

   bplm_ctrl u_ctrl (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .stat(stat),
      .cmd(cmd)
   );

   bplm_dp #(.NUM_BUFFERS(NUM_BUFFERS)) u_dp (
      .clock(clock),
      .reset(reset),
      .cmd(cmd),
      .stat(stat),
      .req_type(req_type),
      .req_buffer_index(req_buffer_index),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_granted_index(rsp_granted_index),
      .rsp_outcome(rsp_outcome)
   );

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while one is in flight");

   a_load_shows: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> rsp_valid)
      else $error("response load did not raise rsp_valid");

   a_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> !(rsp_valid && !rsp_ready))
      else $error("response overwritten before it was taken");

   a_outcome_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_outcome != OUT_UNUSED)
      else $error("undefined outcome code");

endmodule
